### rtl/dds_pkg.sv
// Shared types and constants for the detection deadzone steering unit.
`timescale 1ns / 1ps

package dds_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_CONF_THRESHOLD = 3'd0;
  localparam logic [2:0] REG_DEADZONE_WIDTH = 3'd1;
  localparam logic [2:0] REG_LEFT_CODE      = 3'd2;
  localparam logic [2:0] REG_RIGHT_CODE     = 3'd3;
  localparam logic [2:0] REG_FORWARD_CODE   = 3'd4;
  localparam logic [2:0] REG_STOP_CODE      = 3'd5;

  // Configuration reset values
  localparam logic [15:0] RST_CONF_THRESHOLD = 16'd16384;
  localparam logic [6:0]  RST_DEADZONE_WIDTH = 7'd16;
  localparam logic [7:0]  RST_LEFT_CODE      = 8'd1;
  localparam logic [7:0]  RST_RIGHT_CODE     = 8'd2;
  localparam logic [7:0]  RST_FORWARD_CODE   = 8'd3;
  localparam logic [7:0]  RST_STOP_CODE      = 8'd4;

  localparam logic [7:0] PACKET_HEAD = 8'hAA;

  // Command queue between decision stage and byte serializer
  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_AW    = 2;
  localparam int CMDQ_CW    = 3;

  // Position within the three-byte packet
  typedef enum logic [2:0] {
    BYTE_HEAD = 3'b001,
    BYTE_CMD  = 3'b010,
    BYTE_INV  = 3'b100
  } byte_pos_t;

endpackage

### rtl/detection_deadzone_steering_unit.sv
// Top level: best-box tracking, deadzone steering decision and packet output.
`timescale 1ns / 1ps

// Flow: an accepted item is captured in the evaluation register and weighed;
//   if it ends a frame with a new command, its packet (head 0xAA) is queued.
// Throughput: one input transaction per cycle; each packet takes three output
//   transactions. Up to four packets queue; in_stall rises only when that
//   command queue (plus the item in the evaluation register) is full.
// Reset (rst_n low, synchronous): config returns to defaults, best box, last
//   sent command, queue and serializer clear.
module detection_deadzone_steering_unit #(
  parameter int MODEL_WIDTH = 96
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write port
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_box_present,
  input  logic [15:0] in_box_confidence,
  input  logic [6:0]  in_box_left,
  input  logic [6:0]  in_box_width,
  input  logic        in_frame_last,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_tx_byte,
  output logic        out_packet_end
);

  // Screen midpoint as a signed constant, wide enough for band edge math
  localparam int MID = MODEL_WIDTH / 2;
  localparam logic signed [9:0] MID_S = 10'(MID);

  // ---------------- configuration registers ----------------
  logic [15:0] conf_thr_r;
  logic [6:0]  dz_width_r;
  logic [7:0]  left_code_r;
  logic [7:0]  right_code_r;
  logic [7:0]  fwd_code_r;
  logic [7:0]  stop_code_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      conf_thr_r   <= dds_pkg::RST_CONF_THRESHOLD;
      dz_width_r   <= dds_pkg::RST_DEADZONE_WIDTH;
      left_code_r  <= dds_pkg::RST_LEFT_CODE;
      right_code_r <= dds_pkg::RST_RIGHT_CODE;
      fwd_code_r   <= dds_pkg::RST_FORWARD_CODE;
      stop_code_r  <= dds_pkg::RST_STOP_CODE;
    end else if (cfg_wr_en) begin
      // indexes beyond the register list fall through and are ignored
      case (cfg_index)
        dds_pkg::REG_CONF_THRESHOLD: conf_thr_r   <= cfg_wdata;
        dds_pkg::REG_DEADZONE_WIDTH: dz_width_r   <= cfg_wdata[6:0];
        dds_pkg::REG_LEFT_CODE:      left_code_r  <= cfg_wdata[7:0];
        dds_pkg::REG_RIGHT_CODE:     right_code_r <= cfg_wdata[7:0];
        dds_pkg::REG_FORWARD_CODE:   fwd_code_r   <= cfg_wdata[7:0];
        dds_pkg::REG_STOP_CODE:      stop_code_r  <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // ---------------- input register ----------------
  logic        in_fire;
  logic        s1_valid_r;
  logic        s1_present_r;
  logic [15:0] s1_conf_r;
  logic [6:0]  s1_left_r;
  logic [6:0]  s1_width_r;
  logic        s1_last_r;

  assign in_fire = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_present_r <= in_box_present;
      s1_conf_r    <= in_box_confidence;
      s1_left_r    <= in_box_left;
      s1_width_r   <= in_box_width;
      s1_last_r    <= in_frame_last;
    end
  end

  // ---------------- evaluation: best box and decision ----------------
  logic [15:0] best_conf_r,   best_conf_nxt;
  logic [7:0]  best_centre_r, best_centre_nxt;
  logic        found_r,       found_nxt;
  logic [7:0]  last_cmd_r,    last_cmd_nxt;

  logic        qualify;
  logic [7:0]  box_centre;
  logic [7:0]  upd_centre;
  logic        upd_found;
  logic signed [9:0] centre_s;
  logic signed [9:0] half_s;
  logic [7:0]  cmd;
  logic        push;

  assign box_centre = 8'(s1_left_r) + 8'(s1_width_r[6:1]);
  assign qualify = s1_present_r && (s1_conf_r >= conf_thr_r) && (s1_conf_r > best_conf_r);

  // state after weighing this item's box, before any frame-end clear
  assign upd_centre = qualify ? box_centre : best_centre_r;
  assign upd_found  = qualify || found_r;

  assign centre_s = signed'(10'(upd_centre));
  assign half_s   = signed'(10'(dz_width_r[6:1]));

  always_comb begin
    if (!upd_found) begin
      cmd = stop_code_r;
    end else if (centre_s < MID_S - half_s) begin
      cmd = left_code_r;
    end else if (centre_s > MID_S + half_s) begin
      cmd = right_code_r;
    end else begin
      cmd = fwd_code_r;
    end
  end

  // zero command and repeat command are both suppressed
  assign push = s1_valid_r && s1_last_r && (cmd != 8'd0) && (cmd != last_cmd_r);

  always_comb begin
    best_conf_nxt   = best_conf_r;
    best_centre_nxt = best_centre_r;
    found_nxt       = found_r;
    last_cmd_nxt    = last_cmd_r;
    if (s1_valid_r) begin
      best_centre_nxt = upd_centre;
      if (s1_last_r) begin
        best_conf_nxt = 16'd0;
        found_nxt     = 1'b0;
      end else begin
        best_conf_nxt = qualify ? s1_conf_r : best_conf_r;
        found_nxt     = upd_found;
      end
      if (push) begin
        last_cmd_nxt = cmd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_conf_r   <= 16'd0;
      best_centre_r <= 8'd0;
      found_r       <= 1'b0;
      last_cmd_r    <= 8'd0;
    end else begin
      best_conf_r   <= best_conf_nxt;
      best_centre_r <= best_centre_nxt;
      found_r       <= found_nxt;
      last_cmd_r    <= last_cmd_nxt;
    end
  end

  // ---------------- command queue ----------------
  logic [7:0]                 cmdq_mem_r [dds_pkg::CMDQ_DEPTH];
  logic [dds_pkg::CMDQ_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [dds_pkg::CMDQ_CW-1:0] count_r, count_nxt;
  logic                       pop;
  logic                       out_fire;
  logic [dds_pkg::CMDQ_CW-1:0] occupancy;

  // the item in the evaluation register may still push one command
  assign occupancy = count_r + dds_pkg::CMDQ_CW'(s1_valid_r);
  assign in_stall  = (occupancy >= dds_pkg::CMDQ_CW'(dds_pkg::CMDQ_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      cmdq_mem_r[wr_ptr_r] <= cmd;
    end
  end

  always_comb begin
    count_nxt = count_r;
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  // ---------------- packet serializer ----------------
  dds_pkg::byte_pos_t pos_r, pos_nxt;
  logic [7:0]         head_cmd;

  assign head_cmd  = cmdq_mem_r[rd_ptr_r];
  assign out_valid = (count_r != '0);
  assign out_fire  = out_valid && !out_stall;
  assign pop       = out_fire && (pos_r == dds_pkg::BYTE_INV);

  always_comb begin
    out_tx_byte    = dds_pkg::PACKET_HEAD;
    out_packet_end = 1'b0;
    pos_nxt        = pos_r;
    unique case (pos_r)
      dds_pkg::BYTE_HEAD: begin
        out_tx_byte = dds_pkg::PACKET_HEAD;
        if (out_fire) pos_nxt = dds_pkg::BYTE_CMD;
      end
      dds_pkg::BYTE_CMD: begin
        out_tx_byte = head_cmd;
        if (out_fire) pos_nxt = dds_pkg::BYTE_INV;
      end
      dds_pkg::BYTE_INV: begin
        out_tx_byte    = ~head_cmd;
        out_packet_end = 1'b1;
        if (out_fire) pos_nxt = dds_pkg::BYTE_HEAD;
      end
      default: begin
        pos_nxt = dds_pkg::BYTE_HEAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= dds_pkg::BYTE_HEAD;
    end else begin
      pos_r <= pos_nxt;
    end
  end

endmodule
